### rtl/core/bmre_pkg.sv
package bmre_pkg;

    localparam int NUM_MAPS_DEF  = 4;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int ROW_WORDS_DEF = 8;

    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;
    localparam int COUNT_W    = 9;
    localparam int TYPE_W     = 3;
    localparam int MAP_W      = 2;
    localparam int ROW_W      = 8;
    localparam int COL_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic [TYPE_W-1:0] REQ_SET_BIT    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_CLEAR_BIT  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_READ_BIT   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_OR_ROW     = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_OR_AND_NOT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_BIT,
        KIND_ROW
    } t_kind;

    typedef struct packed {
        logic latch;
        logic clear;
        logic rd_src;
        logic rd_dest;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  clear_last;
        logic  out_free;
    } t_status;

endpackage

### rtl/core/bmre_ctrl.sv
module bmre_ctrl
    import bmre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD1   = 5'b00100,
        S_RD2   = 5'b01000,
        S_WR    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.latch   = accept;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_status.kind)
                        KIND_BIT: n_state = S_RD2;
                        KIND_ROW: n_state = S_RD1;
                        default:  n_state = S_WR;
                    endcase
                end
            end
            S_RD1: begin
                o_cmd.rd_src = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_dest = 1'b1;
                n_state       = S_WR;
            end
            S_WR: begin
                // Hold here until the result register can take the beat.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    a_finish_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && i_status.out_free) |=> (r_state == S_IDLE))
        else $error("finished request did not return to idle");

    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_status.clear_last) |=> (r_state == S_CLEAR))
        else $error("clearing pass left early");

endmodule

### rtl/core/bmre_datapath.sv
module bmre_datapath
    import bmre_pkg::*;
#(
    parameter int NUM_MAPS  = NUM_MAPS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int ROW_WORDS = ROW_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic [TYPE_W-1:0]    i_req_type,
    input  logic [MAP_W-1:0]     i_dest_map,
    input  logic [ROW_W-1:0]     i_dst_row,
    input  logic [COL_W-1:0]     i_column,
    input  logic [MAP_W-1:0]     i_src_a_map,
    input  logic [ROW_W-1:0]     i_src_a_row,
    input  logic [MAP_W-1:0]     i_src_b_map,
    input  logic [ROW_W-1:0]     i_src_b_row,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_bit_value,
    output logic                 o_changed,
    output logic                 o_range_error,
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int TOTAL_ROWS = NUM_MAPS * MAX_ROWS;
    localparam int ADDR_W     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int ROW_BITS   = ROW_WORDS * WORD_BITS;

    logic [ROW_BITS-1:0] mem [TOTAL_ROWS];

    logic [COUNT_W-1:0]  r_col_count;
    logic [COUNT_W-1:0]  r_row_count;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_dest_addr;
    logic [ADDR_W-1:0]   r_a_addr;
    logic [ADDR_W-1:0]   r_b_addr;
    logic [COL_W-1:0]    r_col;
    logic                r_err;
    logic                r_write_op;
    logic                r_is_read;
    logic                r_is_or;
    logic                r_is_andn;
    logic                r_is_bit;
    logic                r_col_set;
    logic [ROW_BITS-1:0] r_rd0;
    logic [ROW_BITS-1:0] r_rd1;
    logic [ROW_BITS-1:0] r_src;
    logic                r_out_valid;
    logic                r_bit_value;
    logic                r_changed;
    logic                r_range_error;

    logic                ok_dest;
    logic                ok_a;
    logic                ok_b;
    logic                col_ok;
    logic                in_err;
    t_kind               in_kind;
    logic [1:0]          word_shift;
    logic [ROW_BITS-1:0] use_mask;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_BITS-1:0] new_row;
    logic                row_changed;
    logic                bit_read;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;

    function automatic logic row_ok(input logic [MAP_W-1:0] map, input logic [ROW_W-1:0] row,
                                    input logic [COUNT_W-1:0] count);
        return (int'(map) < NUM_MAPS) && ({1'b0, row} < count) && (int'(row) < MAX_ROWS);
    endfunction

    function automatic logic [ADDR_W-1:0] row_addr(input logic [MAP_W-1:0] map,
                                                   input logic [ROW_W-1:0] row);
        return ADDR_W'(int'(map) * MAX_ROWS + int'(row));
    endfunction

    // Request check against the current counts, done as the beat arrives.
    always_comb begin
        ok_dest = row_ok(i_dest_map, i_dst_row, r_row_count);
        ok_a    = row_ok(i_src_a_map, i_src_a_row, r_row_count);
        ok_b    = row_ok(i_src_b_map, i_src_b_row, r_row_count);
        col_ok  = ({1'b0, i_column} < r_col_count)
                  && (int'(i_column >> WORD_SHIFT) < ROW_WORDS);
        in_err  = 1'b0;
        in_kind = KIND_SKIP;
        case (i_req_type)
            REQ_SET_BIT, REQ_CLEAR_BIT, REQ_READ_BIT: begin
                in_err  = !ok_dest || !col_ok;
                in_kind = in_err ? KIND_SKIP : KIND_BIT;
            end
            REQ_OR_ROW: begin
                in_err  = !ok_dest || !ok_a;
                in_kind = in_err ? KIND_SKIP : KIND_ROW;
            end
            REQ_OR_AND_NOT: begin
                in_err  = !ok_dest || !ok_a || !ok_b;
                in_kind = in_err ? KIND_SKIP : KIND_ROW;
            end
            default: begin
                in_err  = 1'b0;
                in_kind = KIND_SKIP;
            end
        endcase
    end

    // Words in use: 2^s, with s the number of the thresholds 64, 128 and 256 that the count reaches.
    always_comb begin
        if (r_col_count >= COUNT_W'(256)) begin
            word_shift = 2'd3;
        end else if (r_col_count >= COUNT_W'(128)) begin
            word_shift = 2'd2;
        end else if (r_col_count >= COUNT_W'(64)) begin
            word_shift = 2'd1;
        end else begin
            word_shift = 2'd0;
        end
        for (int w = 0; w < ROW_WORDS; w++) begin
            use_mask[w*WORD_BITS +: WORD_BITS] = {WORD_BITS{(w < (32'd1 << word_shift))}};
        end
    end

    always_comb begin
        bit_mask    = {{(ROW_BITS-1){1'b0}}, 1'b1} << r_col;
        bit_read    = |(r_rd0 & bit_mask);
        row_changed = r_is_or && (|(r_src & use_mask & ~r_rd0));
        if (r_is_bit) begin
            new_row = r_col_set ? (r_rd0 | bit_mask) : (r_rd0 & ~bit_mask);
        end else begin
            new_row = r_rd0 | (r_src & use_mask);
        end
    end

    assign mem_we    = i_cmd.clear || (i_cmd.finish && r_write_op);
    assign mem_waddr = i_cmd.clear ? r_clr_addr : r_dest_addr;
    assign mem_wdata = i_cmd.clear ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_src || i_cmd.rd_dest) begin
            r_rd0 <= mem[i_cmd.rd_src ? r_a_addr : r_dest_addr];
        end
        if (i_cmd.rd_src) begin
            r_rd1 <= mem[r_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count   <= COUNT_RESET;
            r_row_count   <= COUNT_RESET;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                    CFG_ROW_COUNT:    r_row_count <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_dest_addr <= row_addr(i_dest_map, i_dst_row);
            r_a_addr    <= row_addr(i_src_a_map, i_src_a_row);
            r_b_addr    <= row_addr(i_src_b_map, i_src_b_row);
            r_col       <= i_column;
            r_err       <= in_err;
            r_is_bit    <= (in_kind == KIND_BIT);
            r_is_read   <= (in_kind == KIND_BIT) && (i_req_type == REQ_READ_BIT);
            r_col_set   <= (i_req_type == REQ_SET_BIT);
            r_is_or     <= (in_kind == KIND_ROW) && (i_req_type == REQ_OR_ROW);
            r_is_andn   <= (in_kind == KIND_ROW) && (i_req_type == REQ_OR_AND_NOT);
            r_write_op  <= (in_kind == KIND_ROW)
                           || ((in_kind == KIND_BIT) && (i_req_type != REQ_READ_BIT));
        end
        // Source row: A alone, or A with B masked out for or-and-not.
        if (i_cmd.rd_dest) begin
            r_src <= r_is_andn ? (r_rd0 & ~r_rd1) : r_rd0;
        end
        if (i_cmd.finish) begin
            r_bit_value   <= r_is_read && bit_read;
            r_changed     <= row_changed;
            r_range_error <= r_err;
        end
    end

    assign o_status.kind       = in_kind;
    assign o_status.clear_last = (r_clr_addr == ADDR_W'(TOTAL_ROWS - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_bit_value   = r_bit_value;
    assign o_changed     = r_changed;
    assign o_range_error = r_range_error;

endmodule

### rtl/core/bit_matrix_row_engine.sv
// Steps: a bit request reads its row (RD2) and then finishes (WR), a row request reads its
// sources (RD1) before that, and a request that fails its range check or has an unknown type
// goes straight to WR. WR waits until the result register is free. Only one request is in
// flight at a time, set by the row-wide store being read before it is written.
// Reset: a clearing pass writes zero to all NUM_MAPS*MAX_ROWS rows, one per cycle;
// no request is taken meanwhile, configuration writes are.
module bit_matrix_row_engine
    import bmre_pkg::*;
#(
    parameter int NUM_MAPS  = NUM_MAPS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int ROW_WORDS = ROW_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TYPE_W-1:0]    i_req_type,
    input  logic [MAP_W-1:0]     i_dest_map,
    input  logic [ROW_W-1:0]     i_dst_row,
    input  logic [COL_W-1:0]     i_column,
    input  logic [MAP_W-1:0]     i_src_a_map,
    input  logic [ROW_W-1:0]     i_src_a_row,
    input  logic [MAP_W-1:0]     i_src_b_map,
    input  logic [ROW_W-1:0]     i_src_b_row,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_bit_value,
    output logic                 o_changed,
    output logic                 o_range_error
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    bmre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bmre_datapath #(
        .NUM_MAPS  (NUM_MAPS),
        .MAX_ROWS  (MAX_ROWS),
        .ROW_WORDS (ROW_WORDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_dest_map    (i_dest_map),
        .i_dst_row     (i_dst_row),
        .i_column      (i_column),
        .i_src_a_map   (i_src_a_map),
        .i_src_a_row   (i_src_a_row),
        .i_src_b_map   (i_src_b_map),
        .i_src_b_row   (i_src_b_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bit_value   (o_bit_value),
        .o_changed     (o_changed),
        .o_range_error (o_range_error),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule
